// ----- src/glse_pkg.sv -----
package glse_pkg;

  localparam int GROUPS = 16;
  localparam int NREPORT = (GROUPS < 16) ? GROUPS : 16;
  localparam int GW = $clog2(GROUPS);
  localparam int RW = $clog2(NREPORT);

  localparam int TAYLOR_TERMS = 24;
  localparam int LN_BITS = 24;

  localparam logic [31:0] SUM_ONE = 32'h0080_0000;
  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [63:0] Q30_HALF = 64'h0000_0000_2000_0000;
  localparam logic [63:0] LN_ROUND = 64'h0000_0080_0000_0000;
  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

  // exp(1.0) from the truncating series, and its rounded reciprocal exp(-1.0) in Q2.30.
  localparam logic [63:0] EXP1_Q30 = 64'd2918732883;
  localparam logic [63:0] EM1_WIDE = ((64'd1 << 60) + (EXP1_Q30 >> 1)) / EXP1_Q30;
  localparam logic [28:0] EM1_Q30 = EM1_WIDE[28:0];

  // floor(2^31 / n) for the series division by the term number.
  localparam logic [63:0] RB = 64'd2147483648;
  localparam logic [31:0] RECIP_TAB [TAYLOR_TERMS + 1] = '{
    32'd0,         32'(RB / 1),  32'(RB / 2),  32'(RB / 3),  32'(RB / 4),
    32'(RB / 5),   32'(RB / 6),  32'(RB / 7),  32'(RB / 8),  32'(RB / 9),
    32'(RB / 10),  32'(RB / 11), 32'(RB / 12), 32'(RB / 13), 32'(RB / 14),
    32'(RB / 15),  32'(RB / 16), 32'(RB / 17), 32'(RB / 18), 32'(RB / 19),
    32'(RB / 20),  32'(RB / 21), 32'(RB / 22), 32'(RB / 23), 32'(RB / 24)
  };

  localparam int DIV_NW = 61;
  localparam int DIV_DW = 32;
  localparam int DIV_QW = 31;

  typedef struct packed {
    logic busy;
    logic done;
  } glse_div_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_EXP_MUL,
    S_EXP_DIV,
    S_EXP_COR,
    S_EXP_ACC,
    S_RECIP,
    S_RECIP_WAIT,
    S_EI_MUL,
    S_EI_RND,
    S_UPD_MUL,
    S_UPD,
    S_ROWCHK,
    S_REP_RD,
    S_REP_LOAD,
    S_LN_MUL,
    S_LN_RND,
    S_SC_MUL,
    S_SC,
    S_OUT
  } glse_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/glse_ram.sv -----
module glse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/glse_div.sv -----
module glse_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [glse_pkg::DIV_NW-1:0]     num,
  input  logic [glse_pkg::DIV_DW-1:0]     den,
  output logic [glse_pkg::DIV_QW-1:0]     quot,
  output glse_pkg::glse_div_stat_t        stat
);

  localparam int NW = glse_pkg::DIV_NW;
  localparam int DW = glse_pkg::DIV_DW;
  localparam int QW = glse_pkg::DIV_QW;
  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] nsh_r;
  logic [QW-1:0] quot_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;

  // The upper numerator bits are below the divisor, so only the low quotient bits are formed.
  always_comb begin
    trial = {rem_r, nsh_r[QW-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= DW'(num[NW-1:QW]);
      nsh_r <= num[QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= qbit ? diff[DW-1:0] : trial[DW-1:0];
      nsh_r  <= {nsh_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], qbit};
    end
  end

  assign quot = quot_r;
  assign stat = '{busy: busy_r, done: done_r};

endmodule

// ----- src/grouped_log_sum_exp.sv -----
// Per-group online log-sum-exp. A prior transaction (tuser 0) loads one group's log prior or
// marks it zero. A sample transaction (tuser 1) adds loglik + log_weight to its group's
// running maximum and scaled sum, held in a registered-read RAM and updated by a
// read-modify-write sequencer around one shared 32x32 multiplier. For a later sample of a
// group, exp(-x) is built from series terms up to the first zero term (at most 24), the
// bit-serial reciprocal, and one multiply by exp(-1) per integer unit of x (at most 31); a
// sample whose value lies 32.0 or more from the group maximum skips these steps. A sample
// with tlast then reports every group in turn; each group with a sum and a nonzero prior
// runs 24 squaring steps of the log2 loop. Results leave through an output register, and
// the next transaction is taken while the last result waits there.
module grouped_log_sum_exp (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // group[3:0], loglik[35:4], log_weight[67:36], log_prior[99:68], prior_zero[100], zero fill
  input  logic [103:0] in_tdata,
  // req_type
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // group_index[3:0], log_density[35:4], zero fill
  output logic [39:0]  out_tdata,
  // is_neg_inf
  output logic         out_tuser,
  output logic         out_tlast
);

  localparam int GW = glse_pkg::GW;
  localparam int RW = glse_pkg::RW;

  glse_pkg::glse_state_t st_r, st_nxt;

  logic              in_fire;
  logic [3:0]        in_group;
  logic [31:0]       in_loglik;
  logic [31:0]       in_log_weight;
  logic [31:0]       in_log_prior;
  logic              in_prior_zero;
  logic              g_ok;
  logic signed [31:0] in_val;

  logic [GW-1:0]     g_addr_r;
  logic              g_ok_r;
  logic              last_r;
  logic signed [31:0] val_r;
  logic signed [31:0] cur_max_r;
  logic [31:0]       cur_sum_r;
  logic              gt_r;
  logic [15:0]       f_r;
  logic [4:0]        ip_r;
  logic [30:0]       term_r;
  logic [31:0]       esum_r;
  logic [4:0]        n_r;
  logic [29:0]       v_r;
  logic [30:0]       e_r;
  logic [63:0]       prod_r;
  logic [30:0]       m_r;
  logic [27:0]       l_r;
  logic [4:0]        bit_r;
  logic [RW-1:0]     rep_r;
  logic signed [31:0] prior_r;
  logic signed [31:0] res_r;
  logic              res_inf_r;
  logic [glse_pkg::GROUPS-1:0] seen_r;
  logic [glse_pkg::GROUPS-1:0] pv_r;

  logic              out_tvalid_r;
  logic [3:0]        out_group_r;
  logic signed [31:0] out_dens_r;
  logic              out_inf_r;
  logic              out_last_r;
  logic              out_load;

  logic              st_we, st_re, pr_we, pr_re;
  logic [GW-1:0]     st_waddr, st_raddr, pr_waddr, pr_raddr;
  logic [63:0]       st_wdata, st_rdata;
  logic [31:0]       pr_rdata;

  logic [31:0]       mul_a, mul_b;
  logic              div_start;
  logic [glse_pkg::DIV_NW-1:0] div_num;
  logic [glse_pkg::DIV_QW-1:0] div_quot;
  glse_pkg::glse_div_stat_t    div_stat;

  logic signed [31:0] ld_max;
  logic [31:0]       ld_sum;
  logic [32:0]       ld_diff, ld_ndiff;
  logic              ld_gt;
  logic [31:0]       ld_x;
  logic              ld_big;
  logic [29:0]       cor_q0;
  logic [34:0]       cor_qn, cor_rem;
  logic [30:0]       cor_term;
  logic [63:0]       rnd30;
  logic [30:0]       ei_round;
  logic [33:0]       upd_gt_sum;
  logic [32:0]       upd_le_sum;
  logic [31:0]       upd_sum;
  logic signed [31:0] upd_max;
  logic [31:0]       ln_v;
  logic [4:0]        ln_p;
  logic [30:0]       ln_m0;
  logic [27:0]       ln_l0;
  logic [31:0]       ln_mr;
  logic [63:0]       sc_tmp;
  logic [20:0]       ln_q;
  logic signed [33:0] sc_sum;
  logic              rep_last;
  logic [GW-1:0]     rep_addr;

  assign in_group      = in_tdata[3:0];
  assign in_loglik     = in_tdata[35:4];
  assign in_log_weight = in_tdata[67:36];
  assign in_log_prior  = in_tdata[99:68];
  assign in_prior_zero = in_tdata[100];

  assign in_tready = (st_r == glse_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign g_ok      = (32'(in_group) < glse_pkg::GROUPS);
  assign in_val    = glse_pkg::sat32($signed({{2{in_loglik[31]}}, in_loglik})
                                     + $signed({{2{in_log_weight[31]}}, in_log_weight}));

  assign pr_we    = in_fire && !in_tuser && g_ok;
  assign pr_waddr = GW'(in_group);
  assign rep_addr = GW'(rep_r);
  assign rep_last = (rep_r == RW'(glse_pkg::NREPORT - 1));
  assign div_num  = {1'b1, 60'd0} + glse_pkg::DIV_NW'(esum_r >> 1);

  glse_ram #(.WIDTH(64), .DEPTH(glse_pkg::GROUPS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  glse_ram #(.WIDTH(32), .DEPTH(glse_pkg::GROUPS)) u_prior_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (in_log_prior),
    .re    (pr_re),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  glse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (esum_r),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  always_comb begin
    ld_max   = $signed(st_rdata[63:32]);
    ld_sum   = st_rdata[31:0];
    ld_diff  = {val_r[31], val_r} - {ld_max[31], ld_max};
    ld_ndiff = 33'd0 - ld_diff;
    ld_gt    = (val_r > ld_max);
    ld_x     = ld_gt ? ld_diff[31:0] : ld_ndiff[31:0];
    ld_big   = |ld_x[31:21];

    cor_q0   = prod_r[60:31];
    cor_qn   = 35'(cor_q0) * 35'(n_r);
    cor_rem  = 35'(v_r) - cor_qn;
    cor_term = (cor_rem >= 35'(n_r)) ? 31'(cor_q0) + 31'd1 : 31'(cor_q0);

    rnd30    = prod_r + glse_pkg::Q30_HALF;
    ei_round = rnd30[60:30];

    upd_gt_sum = rnd30[63:30] + 34'(glse_pkg::SUM_ONE);
    upd_le_sum = 33'(cur_sum_r) + 33'((32'(e_r) + 32'd64) >> 7);
    if (gt_r) begin
      upd_sum = (|upd_gt_sum[33:32]) ? glse_pkg::SUM_MAX : upd_gt_sum[31:0];
      upd_max = val_r;
    end else begin
      upd_sum = upd_le_sum[32] ? glse_pkg::SUM_MAX : upd_le_sum[31:0];
      upd_max = cur_max_r;
    end

    ln_v = (ld_sum < glse_pkg::SUM_ONE) ? glse_pkg::SUM_ONE : ld_sum;
    ln_p = 5'd23;
    for (int k = 24; k < 32; k++) begin
      if (ln_v[k]) begin
        ln_p = 5'(k);
      end
    end
    ln_m0 = (ln_p == 5'd31) ? ln_v[31:1] : 31'(ln_v << (5'd30 - ln_p));
    ln_l0 = {4'(ln_p - 5'd23), 24'd0};
    ln_mr = rnd30[61:30];

    sc_tmp = prod_r + glse_pkg::LN_ROUND;
    ln_q   = sc_tmp[60:40];
    sc_sum = $signed({{2{cur_max_r[31]}}, cur_max_r}) + $signed({13'd0, ln_q})
             - $signed({{2{prior_r[31]}}, prior_r});
  end

  always_comb begin
    st_nxt    = st_r;
    st_re     = 1'b0;
    st_raddr  = rep_addr;
    st_we     = 1'b0;
    st_waddr  = g_addr_r;
    st_wdata  = {val_r, glse_pkg::SUM_ONE};
    pr_re     = 1'b0;
    pr_raddr  = rep_addr;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;
    unique case (st_r)
      glse_pkg::S_IDLE: begin
        if (in_fire && in_tuser) begin
          st_re    = g_ok;
          st_raddr = GW'(in_group);
          st_nxt   = glse_pkg::S_LOAD;
        end
      end
      glse_pkg::S_LOAD: begin
        if (!g_ok_r) begin
          st_nxt = glse_pkg::S_ROWCHK;
        end else if (!seen_r[g_addr_r]) begin
          st_we  = 1'b1;
          st_nxt = glse_pkg::S_ROWCHK;
        end else if (ld_big) begin
          st_nxt = glse_pkg::S_UPD_MUL;
        end else begin
          st_nxt = glse_pkg::S_EXP_MUL;
        end
      end
      glse_pkg::S_EXP_MUL: begin
        mul_a  = 32'(term_r);
        mul_b  = 32'(f_r);
        st_nxt = glse_pkg::S_EXP_DIV;
      end
      glse_pkg::S_EXP_DIV: begin
        mul_a  = 32'(prod_r[45:16]);
        mul_b  = glse_pkg::RECIP_TAB[n_r];
        st_nxt = glse_pkg::S_EXP_COR;
      end
      glse_pkg::S_EXP_COR: begin
        st_nxt = glse_pkg::S_EXP_ACC;
      end
      glse_pkg::S_EXP_ACC: begin
        if (term_r == '0 || n_r == 5'(glse_pkg::TAYLOR_TERMS)) begin
          st_nxt = glse_pkg::S_RECIP;
        end else begin
          st_nxt = glse_pkg::S_EXP_MUL;
        end
      end
      glse_pkg::S_RECIP: begin
        div_start = 1'b1;
        st_nxt    = glse_pkg::S_RECIP_WAIT;
      end
      glse_pkg::S_RECIP_WAIT: begin
        if (div_stat.done) begin
          st_nxt = (ip_r == '0) ? glse_pkg::S_UPD_MUL : glse_pkg::S_EI_MUL;
        end
      end
      glse_pkg::S_EI_MUL: begin
        mul_a  = 32'(e_r);
        mul_b  = 32'(glse_pkg::EM1_Q30);
        st_nxt = glse_pkg::S_EI_RND;
      end
      glse_pkg::S_EI_RND: begin
        st_nxt = (ip_r == 5'd1) ? glse_pkg::S_UPD_MUL : glse_pkg::S_EI_MUL;
      end
      glse_pkg::S_UPD_MUL: begin
        mul_a  = cur_sum_r;
        mul_b  = 32'(e_r);
        st_nxt = glse_pkg::S_UPD;
      end
      glse_pkg::S_UPD: begin
        st_we    = 1'b1;
        st_wdata = {upd_max, upd_sum};
        st_nxt   = glse_pkg::S_ROWCHK;
      end
      glse_pkg::S_ROWCHK: begin
        st_nxt = last_r ? glse_pkg::S_REP_RD : glse_pkg::S_IDLE;
      end
      glse_pkg::S_REP_RD: begin
        st_re  = 1'b1;
        pr_re  = 1'b1;
        st_nxt = glse_pkg::S_REP_LOAD;
      end
      glse_pkg::S_REP_LOAD: begin
        if (seen_r[rep_addr] && pv_r[rep_addr]) begin
          st_nxt = glse_pkg::S_LN_MUL;
        end else begin
          st_nxt = glse_pkg::S_OUT;
        end
      end
      glse_pkg::S_LN_MUL: begin
        mul_a  = 32'(m_r);
        mul_b  = 32'(m_r);
        st_nxt = glse_pkg::S_LN_RND;
      end
      glse_pkg::S_LN_RND: begin
        st_nxt = (bit_r == '0) ? glse_pkg::S_SC_MUL : glse_pkg::S_LN_MUL;
      end
      glse_pkg::S_SC_MUL: begin
        mul_a  = 32'(l_r);
        mul_b  = glse_pkg::LN2_Q32;
        st_nxt = glse_pkg::S_SC;
      end
      glse_pkg::S_SC: begin
        st_nxt = glse_pkg::S_OUT;
      end
      glse_pkg::S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load = 1'b1;
          st_nxt   = rep_last ? glse_pkg::S_IDLE : glse_pkg::S_REP_RD;
        end
      end
      default: begin
        st_nxt = glse_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= glse_pkg::S_IDLE;
      seen_r       <= '0;
      pv_r         <= '0;
      rep_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (pr_we) begin
        pv_r[pr_waddr] <= !in_prior_zero;
      end
      if (st_r == glse_pkg::S_LOAD && g_ok_r) begin
        seen_r[g_addr_r] <= 1'b1;
      end
      if (st_r == glse_pkg::S_ROWCHK) begin
        rep_r <= '0;
      end
      if (out_load) begin
        rep_r <= RW'(rep_r + 1'b1);
        if (rep_last) begin
          seen_r <= '0;
        end
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (out_load) begin
      out_group_r <= 4'(rep_r);
      out_dens_r  <= res_r;
      out_inf_r   <= res_inf_r;
      out_last_r  <= rep_last;
    end
    unique case (st_r)
      glse_pkg::S_IDLE: begin
        if (in_fire) begin
          g_addr_r <= GW'(in_group);
          g_ok_r   <= g_ok;
          last_r   <= in_tlast;
          val_r    <= in_val;
        end
      end
      glse_pkg::S_LOAD: begin
        cur_max_r <= ld_max;
        cur_sum_r <= ld_sum;
        gt_r      <= ld_gt;
        f_r       <= ld_x[15:0];
        ip_r      <= ld_x[20:16];
        term_r    <= glse_pkg::Q30_ONE;
        esum_r    <= 32'(glse_pkg::Q30_ONE);
        n_r       <= 5'd1;
        e_r       <= '0;
      end
      glse_pkg::S_EXP_DIV: begin
        v_r <= prod_r[45:16];
      end
      glse_pkg::S_EXP_COR: begin
        term_r <= cor_term;
      end
      glse_pkg::S_EXP_ACC: begin
        esum_r <= esum_r + 32'(term_r);
        n_r    <= n_r + 5'd1;
      end
      glse_pkg::S_RECIP_WAIT: begin
        if (div_stat.done) begin
          e_r <= div_quot;
        end
      end
      glse_pkg::S_EI_RND: begin
        e_r  <= ei_round;
        ip_r <= ip_r - 5'd1;
      end
      glse_pkg::S_REP_LOAD: begin
        cur_max_r <= ld_max;
        prior_r   <= $signed(pr_rdata);
        m_r       <= ln_m0;
        l_r       <= ln_l0;
        bit_r     <= 5'(glse_pkg::LN_BITS - 1);
        res_r     <= 32'sh8000_0000;
        res_inf_r <= 1'b1;
      end
      glse_pkg::S_LN_RND: begin
        if (ln_mr[31]) begin
          m_r        <= ln_mr[31:1];
          l_r[bit_r] <= 1'b1;
        end else begin
          m_r <= ln_mr[30:0];
        end
        bit_r <= bit_r - 5'd1;
      end
      glse_pkg::S_SC: begin
        res_r     <= glse_pkg::sat32(sc_sum);
        res_inf_r <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_dens_r, out_group_r};
  assign out_tuser  = out_inf_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("Input taken while the reciprocal divider is busy.");

  a_inf_density: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[35:4] == 32'h8000_0000))
    else $error("Minus infinity result without its marker density.");

  a_last_group: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[3:0] == 4'(glse_pkg::NREPORT - 1)))
    else $error("Row end flagged on a group other than the final one.");

  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && rep_last) |=> (seen_r == '0))
    else $error("Group stores not cleared after the row report.");
`endif

endmodule

// ----- dv/grouped_log_sum_exp_tb.sv -----
`timescale 1ns / 1ps

module grouped_log_sum_exp_tb;

  localparam int GROUPS = glse_pkg::GROUPS;
  localparam int NREPORT = glse_pkg::NREPORT;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_OFF = 3000;

  typedef struct {
    logic        req;
    logic [3:0]  grp;
    logic [31:0] loglik;
    logic [31:0] log_weight;
    logic        row_last;
    logic [31:0] log_prior;
    logic        prior_zero;
  } glse_item_t;

  typedef struct {
    logic [3:0]  grp;
    logic [31:0] density;
    logic        neg_inf;
    logic        last;
  } glse_result_t;

  class glse_scoreboard;
    logic signed [31:0] run_max[GROUPS];
    logic [31:0]        run_sum[GROUPS];
    bit                 seen[GROUPS];
    logic signed [31:0] prior_log[GROUPS];
    bit                 prior_ok[GROUPS];
    glse_result_t       densities[$];
    int                 errors;

    function new();
      errors = 0;
      clear_rows();
      for (int g = 0; g < GROUPS; g++) begin
        prior_log[g] = 0;
        prior_ok[g] = 0;
      end
    endfunction

    function void clear_rows();
      for (int g = 0; g < GROUPS; g++) begin
        run_max[g] = 0;
        run_sum[g] = 0;
        seen[g] = 0;
      end
    endfunction

    function longint unsigned exp_pos(longint unsigned f);
      longint unsigned total, term;
      total = 64'h4000_0000;
      term = 64'h4000_0000;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * f) >> 16) / n;
        if (term == 0) break;
        total += term;
      end
      return total;
    endfunction

    function longint unsigned recip(longint unsigned e);
      return ((64'd1 << 60) + (e >> 1)) / e;
    endfunction

    function longint unsigned exp_neg(longint unsigned x);
      longint unsigned ip, e, em1;
      ip = x >> 16;
      if (ip > 31) return 0;
      e = recip(exp_pos(x & 64'hFFFF));
      em1 = recip(exp_pos(64'h10000));
      for (longint unsigned k = 0; k < ip; k++) e = (e * em1 + 64'h2000_0000) >> 30;
      return e;
    endfunction

    function longint ln_sum(logic [31:0] s);
      longint unsigned v, m, l;
      int p;
      v = (s < 32'h0080_0000) ? 64'h0080_0000 : {32'd0, s};
      p = 31;
      while (p > 23 && !v[p]) p--;
      m = (p <= 30) ? (v << (30 - p)) : (v >> 1);
      l = longint'(p - 23) << 24;
      for (int i = 23; i >= 0; i--) begin
        m = (m * m + 64'h2000_0000) >> 30;
        if (m >= (64'd1 << 31)) begin
          l |= 64'd1 << i;
          m >>= 1;
        end
      end
      return longint'((l * 64'hB172_17F8 + (64'd1 << 39)) >> 40);
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function logic [31:0] clip_sum(longint unsigned v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function void accumulate(int g, logic signed [31:0] val);
      longint unsigned e;
      if (!seen[g]) begin
        run_max[g] = val;
        run_sum[g] = 32'h0080_0000;
        seen[g] = 1;
      end else if (val > run_max[g]) begin
        e = exp_neg(longint'(val) - longint'(run_max[g]));
        run_sum[g] = clip_sum(((run_sum[g] * e + 64'h2000_0000) >> 30) + 64'h0080_0000);
        run_max[g] = val;
      end else begin
        e = exp_neg(longint'(run_max[g]) - longint'(val));
        run_sum[g] = clip_sum(run_sum[g] + ((e + 64) >> 7));
      end
    endfunction

    function void note_input(glse_item_t it);
      glse_result_t r;
      if (!it.req) begin
        prior_log[it.grp] = it.log_prior;
        prior_ok[it.grp] = !it.prior_zero;
        return;
      end
      accumulate(int'(it.grp),
                 clip32(longint'($signed(it.loglik)) + longint'($signed(it.log_weight))));
      if (!it.row_last) return;
      for (int g = 0; g < NREPORT; g++) begin
        r.grp = 4'(g);
        if (seen[g] && prior_ok[g]) begin
          r.density = clip32(longint'(run_max[g]) + ln_sum(run_sum[g]) - longint'(prior_log[g]));
          r.neg_inf = 0;
        end else begin
          r.density = 32'h8000_0000;
          r.neg_inf = 1;
        end
        r.last = (g == NREPORT - 1);
        densities.insert(densities.size(), r);
      end
      clear_rows();
    endfunction

    function void check_result(logic [3:0] grp, logic [31:0] density, logic neg_inf, logic last);
      glse_result_t x;
      if (densities.size() == 0) begin
        $display("%0t: unexpected result group %0d density %h", $time, grp, density);
        errors++;
        return;
      end
      x = densities.pop_front();
      if (x.grp !== grp) begin
        $display("%0t: group_index expected %0d actual %0d", $time, x.grp, grp);
        errors++;
      end
      if (x.density !== density) begin
        $display("%0t: log_density expected %h actual %h", $time, x.density, density);
        errors++;
      end
      if (x.neg_inf !== neg_inf) begin
        $display("%0t: is_neg_inf expected %b actual %b", $time, x.neg_inf, neg_inf);
        errors++;
      end
      if (x.last !== last) begin
        $display("%0t: last expected %b actual %b", $time, x.last, last);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [39:0]  out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  glse_scoreboard density_sb;
  int send_idle;
  int recv_idle;
  int hold_cycles;
  int quiet_cycles;

  grouped_log_sum_exp dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      density_sb.check_result(out_tdata[3:0], out_tdata[35:4], out_tuser, out_tlast);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(glse_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.req;
    in_tlast <= it.row_last;
    in_tdata <= {3'd0, it.prior_zero, it.log_prior, it.log_weight, it.loglik, it.grp};
    do @(posedge clk); while (!in_tready);
    density_sb.note_input(it);
  endtask

  task automatic send_prior(int g, logic [31:0] lp, logic pz, logic rl);
    glse_item_t it;
    it.req = 0;
    it.grp = 4'(g);
    it.loglik = $urandom;
    it.log_weight = $urandom;
    it.row_last = rl;
    it.log_prior = lp;
    it.prior_zero = pz;
    send_item(it);
  endtask

  task automatic send_sample(int g, logic [31:0] ll, logic [31:0] lw, logic rl);
    glse_item_t it;
    it.req = 1;
    it.grp = 4'(g);
    it.loglik = ll;
    it.log_weight = lw;
    it.row_last = rl;
    it.log_prior = $urandom;
    it.prior_zero = 1'($urandom_range(1));
    send_item(it);
  endtask

  function automatic logic [31:0] near_value();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(40 << 16) - (20 << 16);
  endfunction

  task automatic send_row();
    int n;
    n = $urandom_range(1, 6);
    if ($urandom_range(99) < 15) begin
      send_prior($urandom_range(15), near_value(), $urandom_range(99) < 20,
                 1'($urandom_range(1)));
    end
    for (int i = 0; i < n; i++) begin
      send_sample($urandom_range(15), near_value(), near_value(), i == n - 1);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (density_sb.densities.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int sent;
    density_sb = new();
    clk = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    in_tlast = 0;
    out_tready = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    send_idle = 9;
    recv_idle = 72;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_prior(0, 32'h7FFF_FFFF, 0, 0);
    send_prior(1, 32'h8000_0000, 0, 1);
    send_prior(2, 32'h0001_0000, 1, 0);
    for (int g = 3; g < 15; g++) send_prior(g, near_value(), 0, g[0]);
    send_prior(15, 32'h0, 0, 1);
    send_sample(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_sample(1, 32'h8000_0000, 32'h8000_0000, 0);
    send_sample(3, 32'h0001_0000, 32'h0, 0);
    send_sample(3, 32'h0001_0000, 32'h0, 0);
    send_sample(3, 32'h0001_8000, 32'h0, 0);
    send_sample(3, 32'hFFD8_0000, 32'h0, 0);
    send_sample(4, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_sample(2, 32'h0, 32'h0, 1);
    send_prior(2, 32'hFFFF_0000, 0, 0);
    send_sample(2, 32'h0002_0000, 32'hFFFF_8000, 1);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 9 : (ph == 1) ? 72 : 0;
      recv_idle = (ph == 0) ? 72 : (ph == 1) ? 9 : 0;
      if (ph == 2) begin
        hold_cycles = HOLD_OFF;
        send_row();
        send_row();
        send_row();
      end
      sent = 0;
      while (sent < 60) begin
        send_row();
        sent += 4;
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (density_sb.errors == 0 && density_sb.densities.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- grouped_log_sum_exp.f -----
src/glse_pkg.sv
src/glse_ram.sv
src/glse_div.sv
src/grouped_log_sum_exp.sv
dv/grouped_log_sum_exp_tb.sv
